// File: rtl/core/tpsa_pkg.sv
package tpsa_pkg;

	// stream payload widths
	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned OUT_DATA_W = 24;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_SCALE  = 2'd1;

	localparam int unsigned SETTLE_W = 16;
	localparam int unsigned TICK_W   = 10;
	localparam logic [SETTLE_W-1:0] SETTLE_TIME_RST = 16'd5000;
	localparam logic [TICK_W-1:0]   TICK_SCALE_RST  = 10'd1;

	localparam int unsigned SAMPLE_COUNT_DEF = 100;

	// field widths
	localparam int unsigned RAW_W  = 12;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned POS_X_W = 9;
	localparam int unsigned POS_Y_W = 8;

	// calibration: x = (raw - X_LOW) / 10.7, y = (Y_ZERO - raw) / 14.1
	localparam int unsigned X_LOW  = 249;
	localparam int unsigned X_HIGH = 3423 + 249;
	localparam int unsigned X_MAX  = 319;
	localparam int unsigned X_DIV  = 107;
	localparam int unsigned Y_CUT  = 3766;
	localparam int unsigned Y_ZERO = 3740;
	localparam int unsigned Y_LOW  = 382;
	localparam int unsigned Y_MAX  = 239;
	localparam int unsigned Y_DIV  = 141;

	// reciprocal multipliers, ten folded in, result taken above CAL_SHIFT
	localparam int unsigned CAL_SHIFT = 22;
	localparam int unsigned CAL_MUL_W = 20;
	localparam int unsigned CAL_PROD_W = 32;
	localparam int unsigned X_MUL = 10 * (((2 ** CAL_SHIFT) + X_DIV - 1) / X_DIV);
	localparam int unsigned Y_MUL = 10 * (((2 ** CAL_SHIFT) + Y_DIV - 1) / Y_DIV);

	typedef struct packed {
		logic [POS_Y_W-1:0] y;
		logic [POS_X_W-1:0] x;
	} point_t;

endpackage

// File: rtl/core/touch_panel_settle_and_average_core.sv
// touch panel settle and average core
// s_* stream: one request per panel poll (pen flag, raw x/y, timestamp).
// m_* stream: exactly one result per poll, in order.
// cfg_*: register writes (settle time, tick scale), always ready; the user
// writes them only while the stream side is idle, which is not enforced.
// pipeline: poll is calibrated into the input register, the qualifier and
// running sums update in stage two, the average multiply and result
// register form stage three, whose result register drives m_tvalid.
// one request is accepted every cycle while the pipeline is not stalled.
// each stage has its own valid bit and loads when empty or when it is
// moving on, so when the receiver stalls the earlier stages keep filling
// and s_tready drops only once all three stages hold a request.
// reset (arst_n low) clears the pipeline, the qualifier (released), sums,
// sample count and the published position, and loads settle time 5000 and
// tick scale 1.
module touch_panel_settle_and_average_core #(
	parameter int unsigned SAMPLE_COUNT = tpsa_pkg::SAMPLE_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pen_down[0], raw_x[12:1], raw_y[24:13], now_ticks[56:25], zero fill
	input  logic [tpsa_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// touched[0], pos_x[9:1], pos_y[17:10], fresh[18], zero fill
	output logic [tpsa_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tpsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [1:0] MODE_RELEASED = 2'd0;
	localparam logic [1:0] MODE_WAITING  = 2'd1;
	localparam logic [1:0] MODE_SETTLED  = 2'd2;

	localparam int unsigned SUM_X_W = $clog2(SAMPLE_COUNT * tpsa_pkg::X_MAX + 1);
	localparam int unsigned SUM_Y_W = $clog2(SAMPLE_COUNT * tpsa_pkg::Y_MAX + 1);
	localparam int unsigned IDX_W   = $clog2(SAMPLE_COUNT + 1);
	localparam int unsigned PROD_W  = tpsa_pkg::SETTLE_W + tpsa_pkg::TICK_W;

	logic [tpsa_pkg::SETTLE_W-1:0] settle_time_q;
	logic [tpsa_pkg::TICK_W-1:0]   tick_scale_q;

	logic [1:0]                    mode_q, mode_d;
	logic [tpsa_pkg::TIME_W-1:0]   press_start_q, press_start_d;
	logic [SUM_X_W-1:0]            sum_x_q, sum_x_d, acc_x;
	logic [SUM_Y_W-1:0]            sum_y_q, sum_y_d, acc_y;
	logic [IDX_W-1:0]              idx_q, idx_d, idx_inc;
	logic [tpsa_pkg::POS_X_W-1:0]  avg_x_q, quo_x;
	logic [tpsa_pkg::POS_Y_W-1:0]  avg_y_q, quo_y;

	tpsa_pkg::point_t              cal_pt, pt_s1;
	logic                          v_s1, pen_s1;
	logic [tpsa_pkg::TIME_W-1:0]   now_s1;
	logic                          v_s2, touched_s2, done_s2;
	logic [SUM_X_W-1:0]            fin_x_s2;
	logic [SUM_Y_W-1:0]            fin_y_s2;
	logic                          v_s3, touched_s3, fresh_s3;

	logic                          accept, en2, en3, rdy2, rdy3;
	logic                          touched, done, settle_hit;
	logic [tpsa_pkg::TIME_W-1:0]   elapsed;
	logic [PROD_W-1:0]             settle_prod;

	// handshakes
	assign rdy3     = !v_s3 || m_tready;
	assign rdy2     = !v_s2 || rdy3;
	assign s_tready = !v_s1 || rdy2;
	assign accept   = s_tvalid && s_tready;
	assign en2      = v_s1 && rdy2;
	assign en3      = v_s2 && rdy3;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_time_q <= tpsa_pkg::SETTLE_TIME_RST;
			tick_scale_q  <= tpsa_pkg::TICK_SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				tpsa_pkg::REG_SETTLE_TIME: settle_time_q <= cfg_data;
				tpsa_pkg::REG_TICK_SCALE:  tick_scale_q <= cfg_data[tpsa_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// stage one: calibrated poll
	tpsa_calib u_cal (
		.raw_x (s_tdata[12:1]),
		.raw_y (s_tdata[24:13]),
		.point (cal_pt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (en2) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pen_s1 <= s_tdata[0];
			now_s1 <= s_tdata[56:25];
			pt_s1  <= cal_pt;
		end
	end

	// stage two: qualifier and running sums
	// above 16 bits of elapsed ticks any nonzero scale beats the settle time
	assign elapsed     = now_s1 - press_start_q;
	assign settle_prod = PROD_W'(elapsed[tpsa_pkg::SETTLE_W-1:0]) * PROD_W'(tick_scale_q);
	assign settle_hit  = (elapsed[tpsa_pkg::TIME_W-1:tpsa_pkg::SETTLE_W] != '0)
		? (tick_scale_q != '0) : (settle_prod >= PROD_W'(settle_time_q));

	assign acc_x   = sum_x_q + SUM_X_W'(pt_s1.x);
	assign acc_y   = sum_y_q + SUM_Y_W'(pt_s1.y);
	assign idx_inc = idx_q + IDX_W'(1);

	always_comb begin
		mode_d        = mode_q;
		press_start_d = press_start_q;
		sum_x_d       = sum_x_q;
		sum_y_d       = sum_y_q;
		idx_d         = idx_q;
		touched       = 1'b0;
		done          = 1'b0;
		if (!pen_s1) begin
			mode_d  = MODE_RELEASED;
			sum_x_d = '0;
			sum_y_d = '0;
			idx_d   = '0;
		end else begin
			case (mode_q)
				MODE_WAITING: begin
					if (settle_hit) begin
						mode_d = MODE_SETTLED;
					end
				end
				MODE_SETTLED: ;
				default: begin
					press_start_d = now_s1;
					mode_d        = MODE_WAITING;
				end
			endcase
			// the poll that settles is sampled too
			if (mode_d == MODE_SETTLED) begin
				touched = 1'b1;
				if (idx_inc == IDX_W'(SAMPLE_COUNT)) begin
					done    = 1'b1;
					sum_x_d = '0;
					sum_y_d = '0;
					idx_d   = '0;
				end else begin
					sum_x_d = acc_x;
					sum_y_d = acc_y;
					idx_d   = idx_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_RELEASED;
			press_start_q <= '0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			idx_q         <= '0;
			v_s2          <= 1'b0;
		end else begin
			if (en2) begin
				mode_q        <= mode_d;
				press_start_q <= press_start_d;
				sum_x_q       <= sum_x_d;
				sum_y_q       <= sum_y_d;
				idx_q         <= idx_d;
				v_s2          <= 1'b1;
			end else if (en3) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			touched_s2 <= touched;
			done_s2    <= done;
			fin_x_s2   <= acc_x;
			fin_y_s2   <= acc_y;
		end
	end

	// stage three: average and result register
	tpsa_avg_div #(
		.W   (SUM_X_W),
		.DIV (SAMPLE_COUNT),
		.QW  (tpsa_pkg::POS_X_W)
	) u_div_x (
		.sum (fin_x_s2),
		.quo (quo_x)
	);

	tpsa_avg_div #(
		.W   (SUM_Y_W),
		.DIV (SAMPLE_COUNT),
		.QW  (tpsa_pkg::POS_Y_W)
	) u_div_y (
		.sum (fin_y_s2),
		.quo (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			avg_x_q <= '0;
			avg_y_q <= '0;
		end else begin
			if (en3) begin
				v_s3 <= 1'b1;
				if (done_s2) begin
					avg_x_q <= quo_x;
					avg_y_q <= quo_y;
				end
			end else if (m_tready) begin
				v_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			touched_s3 <= touched_s2;
			fresh_s3   <= done_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {5'd0, fresh_s3, avg_y_q, avg_x_q, touched_s3};

endmodule

// File: rtl/core/tpsa_calib.sv
module tpsa_calib (
	input  logic [tpsa_pkg::RAW_W-1:0] raw_x,
	input  logic [tpsa_pkg::RAW_W-1:0] raw_y,
	output tpsa_pkg::point_t           point
);

	logic [tpsa_pkg::RAW_W-1:0]      dx;
	logic [tpsa_pkg::RAW_W-1:0]      dy;
	logic [tpsa_pkg::CAL_PROD_W-1:0] px;
	logic [tpsa_pkg::CAL_PROD_W-1:0] py;

	assign dx = raw_x - tpsa_pkg::RAW_W'(tpsa_pkg::X_LOW);
	assign dy = tpsa_pkg::RAW_W'(tpsa_pkg::Y_ZERO) - raw_y;

	assign px = tpsa_pkg::CAL_PROD_W'(dx)
		* tpsa_pkg::CAL_PROD_W'(tpsa_pkg::CAL_MUL_W'(tpsa_pkg::X_MUL));
	assign py = tpsa_pkg::CAL_PROD_W'(dy)
		* tpsa_pkg::CAL_PROD_W'(tpsa_pkg::CAL_MUL_W'(tpsa_pkg::Y_MUL));

	always_comb begin
		if (raw_x <= tpsa_pkg::RAW_W'(tpsa_pkg::X_LOW)) begin
			point.x = '0;
		end else if (raw_x >= tpsa_pkg::RAW_W'(tpsa_pkg::X_HIGH)) begin
			point.x = tpsa_pkg::POS_X_W'(tpsa_pkg::X_MAX);
		end else begin
			point.x = px[tpsa_pkg::CAL_SHIFT +: tpsa_pkg::POS_X_W];
		end

		// values just above the zero line would go negative, clamp them
		if (raw_y >= tpsa_pkg::RAW_W'(tpsa_pkg::Y_CUT)) begin
			point.y = '0;
		end else if (raw_y <= tpsa_pkg::RAW_W'(tpsa_pkg::Y_LOW)) begin
			point.y = tpsa_pkg::POS_Y_W'(tpsa_pkg::Y_MAX);
		end else if (raw_y >= tpsa_pkg::RAW_W'(tpsa_pkg::Y_ZERO)) begin
			point.y = '0;
		end else begin
			point.y = py[tpsa_pkg::CAL_SHIFT +: tpsa_pkg::POS_Y_W];
		end
	end

endmodule

// File: rtl/core/tpsa_avg_div.sv
module tpsa_avg_div #(
	parameter int unsigned W   = 15,
	parameter int unsigned DIV = tpsa_pkg::SAMPLE_COUNT_DEF,
	parameter int unsigned QW  = 9
) (
	input  logic [W-1:0]  sum,
	output logic [QW-1:0] quo
);

	// exact floor division by a constant through a rounded-up reciprocal
	localparam int unsigned LG = $clog2(DIV);
	localparam int unsigned SH = W + LG;
	localparam int unsigned MW = SH + 1;
	localparam int unsigned PW = W + MW;
	localparam longint unsigned MULT =
		((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

	logic [PW-1:0] prod;

	assign prod = PW'(sum) * PW'(MULT);
	assign quo  = prod[SH +: QW];

endmodule
